// File: hw/rtl/md5_pkg.sv
package md5_pkg;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned LANES       = 4;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FILL_W      = 6;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned IDX_W       = 2;
    // round counter runs two ahead of the round: fetch, add-K, round, then chain add
    localparam int unsigned CNT_W       = 7;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUNDS + 2);

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(LANES - 1);
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] FILL_LEN_START = 6'd56;
    localparam logic [3:0]        LEN_WORD_LO    = 4'd14;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // what the compression sees beyond the stored bytes
    typedef enum logic [1:0] {
        MODE_FULL,      // plain message block
        MODE_PAD_LEN,   // pad byte, zeros, length
        MODE_PAD_ONLY,  // pad byte and zeros, length follows in another block
        MODE_LEN_ONLY   // zeros and length
    } t_mode;

    typedef struct packed {
        logic             start;
        t_mode            mode;
        logic             wr_byte;
        logic             clear;
        logic [IDX_W-1:0] out_idx;
    } t_ctrl_cmd;

    typedef struct packed {
        logic done;
        logic fill_last;  // next byte completes the block
        logic fill_hi;    // no room left for the length in this block
    } t_dp_stat;

    // message word read in a given round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] q;
        logic [3:0] g;
        q = r[3:0];
        case (r[5:4])
            2'd0:    g = q;
            2'd1:    g = 4'(q * 4'd5 + 4'd1);
            2'd2:    g = 4'(q * 4'd3 + 4'd5);
            default: g = 4'(q * 4'd7);
        endcase
        return g;
    endfunction

endpackage

// File: hw/rtl/md5_ram.sv
module md5_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/md5_ctrl.sv
module md5_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_has_byte,
    input  logic                                i_eom,
    input  logic                                i_out_ready,
    input  md5_pkg::t_dp_stat                   i_stat,
    output md5_pkg::t_ctrl_cmd                  o_cmd,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    output logic [md5_pkg::IDX_W-1:0]           o_out_idx
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN,
        ST_RUN,
        ST_OUT
    } t_state;

    t_state                    r_state;
    logic                      r_start;
    md5_pkg::t_mode            r_mode;
    logic                      r_eom;
    logic                      r_ovalid;
    logic [md5_pkg::IDX_W-1:0] r_oidx;
    logic                      in_acc;
    logic                      out_acc;

    assign in_acc  = (r_state == ST_IDLE) && i_in_valid;
    assign out_acc = r_ovalid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_start  <= 1'b0;
            r_mode   <= md5_pkg::MODE_FULL;
            r_eom    <= 1'b0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_has_byte && i_stat.fill_last) begin
                            r_start <= 1'b1;
                            r_mode  <= md5_pkg::MODE_FULL;
                            r_eom   <= i_eom;
                            r_state <= ST_RUN;
                        end else if (i_eom) begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    // fill count is settled here, byte of the end request included
                    r_start <= 1'b1;
                    r_mode  <= i_stat.fill_hi ? md5_pkg::MODE_PAD_ONLY
                                              : md5_pkg::MODE_PAD_LEN;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (i_stat.done) begin
                        case (r_mode)
                            md5_pkg::MODE_FULL: begin
                                r_state <= r_eom ? ST_FIN : ST_IDLE;
                            end
                            md5_pkg::MODE_PAD_ONLY: begin
                                r_start <= 1'b1;
                                r_mode  <= md5_pkg::MODE_LEN_ONLY;
                            end
                            default: begin
                                r_state  <= ST_OUT;
                                r_ovalid <= 1'b1;
                                r_oidx   <= '0;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        if (r_oidx == md5_pkg::LAST_IDX) begin
                            r_ovalid <= 1'b0;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.start   = r_start;
        o_cmd.mode    = r_mode;
        o_cmd.wr_byte = in_acc && i_has_byte;
        o_cmd.clear   = out_acc && (r_oidx == md5_pkg::LAST_IDX);
        o_cmd.out_idx = r_oidx;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_idx   = r_oidx;

endmodule

// File: hw/rtl/md5_dp.sv
module md5_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  md5_pkg::t_ctrl_cmd                 i_cmd,
    input  logic [md5_pkg::BYTE_W-1:0]         i_byte,
    output md5_pkg::t_dp_stat                  o_stat,
    output logic [md5_pkg::WORD_W-1:0]         o_digest
);

    localparam int unsigned W  = md5_pkg::WORD_W;
    localparam int unsigned BW = md5_pkg::BYTE_W;

    logic [W-1:0]                r_chain [md5_pkg::LANES];
    logic [W-1:0]                r_wa, r_wb, r_wc, r_wd;
    logic [W-1:0]                r_mk;
    logic [md5_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_busy;
    logic                        r_done;
    md5_pkg::t_mode              r_mode;
    logic [3:0]                  r_gd;
    logic [md5_pkg::FILL_W-1:0]  r_fill;
    logic [md5_pkg::LEN_W-1:0]   r_bitlen;

    logic [3:0]                  rd_addr;
    logic [W-1:0]                rd_word;
    logic [W-1:0]                msg_word;
    logic [W-1:0]                len_word;
    logic [md5_pkg::FILL_W:0]    lim;
    logic                        pad_en;
    logic                        len_en;
    logic [5:0]                  mk_idx;
    logic [5:0]                  rnd;
    logic [W-1:0]                f_val;
    logic [W-1:0]                sum;
    logic [2*W-1:0]              dbl;
    logic                        mk_phase;
    logic                        rnd_phase;

    // four byte lanes, one word address: a whole message word per read
    for (genvar l = 0; l < md5_pkg::LANES; l++) begin : g_lane
        md5_ram #(
            .WIDTH(BW),
            .DEPTH(md5_pkg::BLOCK_WORDS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_cmd.wr_byte && (r_fill[1:0] == 2'(l))),
            .i_waddr(r_fill[md5_pkg::FILL_W-1:2]),
            .i_wdata(i_byte),
            .i_raddr(rd_addr),
            .o_rdata(rd_word[l*BW +: BW])
        );
    end

    assign rd_addr = md5_pkg::msg_index(r_cnt[5:0]);

    // padding and length are laid over the stored bytes as they are read
    always_comb begin
        logic [md5_pkg::FILL_W:0] pos;
        case (r_mode)
            md5_pkg::MODE_FULL:     lim = 7'd64;
            md5_pkg::MODE_LEN_ONLY: lim = '0;
            default:                lim = {1'b0, r_fill};
        endcase
        pad_en   = (r_mode == md5_pkg::MODE_PAD_LEN) || (r_mode == md5_pkg::MODE_PAD_ONLY);
        len_en   = (r_mode == md5_pkg::MODE_PAD_LEN) || (r_mode == md5_pkg::MODE_LEN_ONLY);
        len_word = r_gd[0] ? r_bitlen[63:32] : r_bitlen[31:0];
        for (int l = 0; l < md5_pkg::LANES; l++) begin
            pos = {1'b0, r_gd, 2'(l)};
            if (pos < lim) begin
                msg_word[l*BW +: BW] = rd_word[l*BW +: BW];
            end else if (pad_en && (pos == lim)) begin
                msg_word[l*BW +: BW] = md5_pkg::PAD_BYTE;
            end else if (len_en && (r_gd >= md5_pkg::LEN_WORD_LO)) begin
                msg_word[l*BW +: BW] = len_word[l*BW +: BW];
            end else begin
                msg_word[l*BW +: BW] = '0;
            end
        end
    end

    assign mk_idx    = 6'(r_cnt - 1'b1);
    assign rnd       = 6'(r_cnt - 2'd2);
    assign mk_phase  = (r_cnt >= 7'd1) && (r_cnt <= 7'(md5_pkg::ROUNDS));
    assign rnd_phase = (r_cnt >= 7'd2) && (r_cnt <= 7'(md5_pkg::ROUNDS + 1));

    always_comb begin
        case (rnd[5:4])
            2'd0:    f_val = (r_wb & r_wc) | (~r_wb & r_wd);
            2'd1:    f_val = (r_wd & r_wb) | (~r_wd & r_wc);
            2'd2:    f_val = r_wb ^ r_wc ^ r_wd;
            default: f_val = r_wc ^ (r_wb | ~r_wd);
        endcase
        sum = f_val + r_wa + r_mk;
        dbl = {sum, sum} << md5_pkg::ROT_TABLE[{rnd[5:4], rnd[1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
            r_mode     <= md5_pkg::MODE_FULL;
            r_fill     <= '0;
            r_bitlen   <= '0;
            r_chain[0] <= md5_pkg::IV_A;
            r_chain[1] <= md5_pkg::IV_B;
            r_chain[2] <= md5_pkg::IV_C;
            r_chain[3] <= md5_pkg::IV_D;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.wr_byte) begin
                r_fill   <= r_fill + 1'b1;
                r_bitlen <= r_bitlen + 64'd8;
            end
            if (i_cmd.clear) begin
                r_fill     <= '0;
                r_bitlen   <= '0;
                r_chain[0] <= md5_pkg::IV_A;
                r_chain[1] <= md5_pkg::IV_B;
                r_chain[2] <= md5_pkg::IV_C;
                r_chain[3] <= md5_pkg::IV_D;
            end
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mode <= i_cmd.mode;
                r_wa   <= r_chain[0];
                r_wb   <= r_chain[1];
                r_wc   <= r_chain[2];
                r_wd   <= r_chain[3];
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                r_gd  <= rd_addr;
                if (mk_phase) begin
                    r_mk <= msg_word + md5_pkg::K_TABLE[mk_idx];
                end
                if (rnd_phase) begin
                    r_wa <= r_wd;
                    r_wd <= r_wc;
                    r_wc <= r_wb;
                    r_wb <= r_wb + dbl[2*W-1:W];
                end
                if (r_cnt == md5_pkg::CNT_LAST) begin
                    r_chain[0] <= r_chain[0] + r_wa;
                    r_chain[1] <= r_chain[1] + r_wb;
                    r_chain[2] <= r_chain[2] + r_wc;
                    r_chain[3] <= r_chain[3] + r_wd;
                    r_busy     <= 1'b0;
                    r_done     <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_stat.done      = r_done;
        o_stat.fill_last = (r_fill == '1);
        o_stat.fill_hi   = (r_fill >= md5_pkg::FILL_LEN_START);
    end

    assign o_digest = r_chain[i_cmd.out_idx];

endmodule

// File: hw/rtl/md5_hash_engine.sv
// MD5 digest engine fed one message byte per request. A byte request (tuser set)
// is taken while the engine is idle; the 64th byte of a block starts the
// compression, one round per cycle through a shared round unit, and tready
// stays low until that compression is done. A request with tlast set finishes
// the message: padding and the bit length are laid over the block buffer as it is
// read. The first digest word is valid once the padded block is compressed, after
// a second compression when 56 or more bytes sit in the last block; if the end
// request's byte also completes a block, that block's compression comes first.
// The digest then leaves as four 32-bit words A, B, C, D (tuser gives the index,
// tlast marks D), byte 0 of each in the low bits, one per cycle while tready is
// high, after which the engine returns to the initial vector for the next message.
module md5_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] has_byte
    input  logic        i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [1:0]  o_m_tuser,   // [1:0] word_index
    output logic        o_m_tlast    // last_word
);

    md5_pkg::t_ctrl_cmd        cmd;
    md5_pkg::t_dp_stat         stat;
    logic [md5_pkg::IDX_W-1:0] out_idx;

    md5_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_has_byte (i_s_tuser),
        .i_eom      (i_s_tlast),
        .i_out_ready(i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_s_tready),
        .o_out_valid(o_m_tvalid),
        .o_out_idx  (out_idx)
    );

    md5_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (i_s_tdata),
        .o_stat  (stat),
        .o_digest(o_m_tdata)
    );

    assign o_m_tuser = out_idx;
    assign o_m_tlast = (out_idx == md5_pkg::LAST_IDX);

endmodule

// File: verif/tb_md5_hash_engine.sv
`timescale 1ns / 100ps

module tb_md5_hash_engine;

    localparam int unsigned HOLD_AT     = 8;     // long sink hold-off after this many words
    localparam int unsigned HOLD_CYCLES = 500;
    localparam int unsigned DOG_LIMIT   = 4000;
    localparam int unsigned DRAIN       = 150;
    localparam int unsigned N_ITEMS     = 360;

    localparam logic [31:0] CHAIN_A = 32'h67452301;
    localparam logic [31:0] CHAIN_B = 32'hefcdab89;
    localparam logic [31:0] CHAIN_C = 32'h98badcfe;
    localparam logic [31:0] CHAIN_D = 32'h10325476;
    localparam logic [7:0]  MARK_BYTE = 8'h80;
    localparam logic [1:0]  WORD_D    = 2'd3;

    typedef struct {
        logic [7:0]  data;
        logic        has_byte;
        logic        eom;
        int unsigned gap;
        logic        sync;     // wait for all digests before offering
    } t_byte_req;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        is_last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    md5_hash_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [7:0] data_byte
        .i_s_tuser  (i_s_tuser),    // [0] has_byte
        .i_s_tlast  (i_s_tlast),    // end_of_message
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // [31:0] digest_word
        .o_m_tuser  (o_m_tuser),    // [1:0] word_index
        .o_m_tlast  (o_m_tlast)     // last_word
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] rnd_k [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    int unsigned rnd_s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // digest state mirrored from the engine
    logic [31:0] md_chain [4];
    logic [7:0]  md_blk [64];
    int unsigned md_fill;
    logic [63:0] md_bits;

    t_byte_req    req_q [$];
    t_digest_word digest_q [$];
    t_byte_req    cur_req;
    t_digest_word want;
    int unsigned  err_cnt = 0;
    int unsigned  gap_cnt = 0;
    logic         drv_nxt;
    int unsigned  word_cnt = 0;
    int unsigned  hold_left = 0;
    int unsigned  sink_wait = 0;
    logic         sink_quiet = 1'b0;
    logic         rdy_nxt;
    int unsigned  dog_cnt = 0;

    task automatic md5_restart();
        md_chain[0] = CHAIN_A;
        md_chain[1] = CHAIN_B;
        md_chain[2] = CHAIN_C;
        md_chain[3] = CHAIN_D;
        md_fill = 0;
        md_bits = '0;
    endtask

    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, m, t;
        int unsigned r, g, s;
        a = md_chain[0];
        b = md_chain[1];
        c = md_chain[2];
        d = md_chain[3];
        for (r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            m = {md_blk[g*4+3], md_blk[g*4+2], md_blk[g*4+1], md_blk[g*4]};
            f = f + a + m + rnd_k[r];
            s = rnd_s[(r / 16) * 4 + r % 4];
            t = (f << s) | (f >> (32 - s));
            a = d;
            d = c;
            c = b;
            b = b + t;
        end
        md_chain[0] = md_chain[0] + a;
        md_chain[1] = md_chain[1] + b;
        md_chain[2] = md_chain[2] + c;
        md_chain[3] = md_chain[3] + d;
    endtask

    // one accepted request: absorb the byte, and on end of message queue the digest
    task automatic md5_absorb(input t_byte_req rq);
        int unsigned i;
        t_digest_word e;
        if (rq.has_byte) begin
            md_blk[md_fill] = rq.data;
            md_fill++;
            md_bits = md_bits + 64'd8;
            if (md_fill == 64) begin
                md5_compress();
                md_fill = 0;
            end
        end
        if (rq.eom) begin
            md_blk[md_fill] = MARK_BYTE;
            for (i = md_fill + 1; i < 64; i++) md_blk[i] = 8'h00;
            // no room for the length: extra block
            if (md_fill >= 56) begin
                md5_compress();
                for (i = 0; i < 56; i++) md_blk[i] = 8'h00;
            end
            for (i = 0; i < 8; i++) md_blk[56+i] = md_bits[8*i +: 8];
            md5_compress();
            for (i = 0; i < 4; i++) begin
                e.word = md_chain[i];
                e.idx = 2'(i);
                e.is_last = (2'(i) == WORD_D);
                digest_q.push_back(e);
            end
            md5_restart();
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (err_cnt < 40) $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void queue_req(input logic [7:0] data, input logic hb, input logic eom,
                                      input int unsigned gap);
        t_byte_req rq;
        rq.data = data;
        rq.has_byte = hb;
        rq.eom = eom;
        rq.gap = gap;
        rq.sync = 1'b0;
        req_q.push_back(rq);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            drv_nxt = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                md5_absorb(cur_req);
                drv_nxt = 1'b0;
            end
            if (!drv_nxt && req_q.size() > 0 && !(req_q[0].sync && digest_q.size() != 0)) begin
                if (gap_cnt < req_q[0].gap) begin
                    gap_cnt++;
                end else begin
                    cur_req = req_q.pop_front();
                    gap_cnt = 0;
                    drv_nxt = 1'b1;
                    i_s_tdata <= cur_req.data;
                    i_s_tuser <= cur_req.has_byte;
                    i_s_tlast <= cur_req.eom;
                end
            end
            i_s_tvalid <= drv_nxt;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("digest word %h with nothing pending", o_m_tdata));
                end else begin
                    want = digest_q.pop_front();
                    if (o_m_tdata !== want.word)
                        report_mismatch($sformatf("word %h, want %h", o_m_tdata, want.word));
                    if (o_m_tuser !== want.idx)
                        report_mismatch($sformatf("index %0d, want %0d", o_m_tuser, want.idx));
                    if (o_m_tlast !== want.is_last)
                        report_mismatch($sformatf("last %b, want %b", o_m_tlast, want.is_last));
                end
                word_cnt++;
                if (o_m_tlast && $urandom_range(0, 2) == 0) sink_quiet = ~sink_quiet;
                sink_wait = sink_quiet ? 0 : $urandom_range(0, 7);
                if (word_cnt == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy_nxt = 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                rdy_nxt = 1'b0;
            end else begin
                rdy_nxt = 1'b1;
            end
            i_m_tready <= rdy_nxt;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                dog_cnt = 0;
            end else begin
                dog_cnt++;
                if (dog_cnt == DOG_LIMIT) begin
                    $display("[%0t] no progress, giving up", $time);
                    $display("** md5_hash_engine: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned n, len, k, pick, gap;
        logic quiet, joined;
        int unsigned edge_len [7];

        edge_len = '{55, 56, 57, 63, 64, 65, 120};
        md5_restart();

        // directed: empty message, byte with end, pad ignored data, idle items
        queue_req(8'hA5, 1'b0, 1'b1, 0);
        queue_req(8'h00, 1'b1, 1'b1, 0);
        queue_req(8'hFF, 1'b1, 1'b1, 3);
        queue_req(8'h61, 1'b1, 1'b0, 0);
        queue_req(8'hFF, 1'b0, 1'b0, 0);
        queue_req(8'h62, 1'b1, 1'b0, 1);
        queue_req(8'h63, 1'b1, 1'b0, 0);
        queue_req(8'h00, 1'b0, 1'b1, 2);
        queue_req(8'hFF, 1'b0, 1'b1, 0);
        queue_req(8'h00, 1'b0, 1'b0, 0);
        queue_req(8'hFF, 1'b1, 1'b0, 0);
        queue_req(8'h00, 1'b1, 1'b0, 0);
        queue_req(8'h5A, 1'b1, 1'b0, 7);
        queue_req(8'hFF, 1'b1, 1'b1, 0);
        n = req_q.size();
        k = n;

        // random messages, lengths mostly short with block edges mixed in
        while (n < N_ITEMS) begin
            pick = $urandom_range(0, 9);
            len = (pick < 3) ? edge_len[$urandom_range(0, 6)] : $urandom_range(0, 12);
            quiet = ($urandom_range(0, 3) == 0);
            joined = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int unsigned i = 0; i < len; i++) begin
                gap = quiet ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 11) == 0)
                    queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, gap);
                queue_req(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1), gap);
                n++;
            end
            if (!joined) begin
                queue_req(8'($urandom_range(0, 255)), 1'b0, 1'b1,
                          quiet ? 0 : $urandom_range(0, 7));
                n++;
            end
        end
        // sender waits for every digest before the random part
        req_q[k].sync = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_s_tvalid || digest_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (digest_q.size() != 0)
            report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));
        if (err_cnt == 0) begin
            $display("** md5_hash_engine: PASSED **");
        end else begin
            $display("** md5_hash_engine: FAILED **");
        end
        $finish;
    end

endmodule

// File: md5_hash_engine.f
hw/rtl/md5_pkg.sv
hw/rtl/md5_ram.sv
hw/rtl/md5_ctrl.sv
hw/rtl/md5_dp.sv
hw/rtl/md5_hash_engine.sv
verif/tb_md5_hash_engine.sv
